/* hdl/gclcf_pkg.sv */
package gclcf_pkg;

  localparam int LINE_DEPTH = 62;
  localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LINE_DEPTH + 1);
  localparam int BYTE_W     = 8;
  localparam int FUNC_W     = 2;

  localparam logic [FUNC_W-1:0] FUNC_CHAR    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TX      = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DISCARD = 2'd2;

  localparam logic [BYTE_W-1:0] CHAR_N     = 8'h4E;
  localparam logic [BYTE_W-1:0] CHAR_STAR  = 8'h2A;
  localparam logic [BYTE_W-1:0] CHAR_QUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_0     = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_9     = 8'h39;

  typedef enum logic [3:0] {
    S_WAIT,
    S_LINENO,
    S_CMD,
    S_QUOTE,
    S_SUM,
    S_READY,
    S_SKIP_RD,
    S_SKIP_CHK,
    S_RD,
    S_CHK,
    S_CR,
    S_LF
  } state_t;

  typedef enum logic [1:0] {
    OSEL_DATA,
    OSEL_CR,
    OSEL_LF
  } out_sel_t;

  typedef struct packed {
    logic     sum_load;
    logic     sum_xor;
    logic     rsum_clr;
    logic     rsum_acc;
    logic     store;
    logic     clear;
    logic     idx_clr;
    logic     idx_inc;
    logic     rd_en;
    logic     out_load;
    out_sel_t out_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic is_digit;
    logic is_nl;
    logic is_n;
    logic is_star;
    logic is_quote;
    logic sum_match;
    logic cnt_nz;
    logic idx_end;
    logic rd_space;
    logic out_free;
  } dp_stat_t;

endpackage

/* hdl/gclcf_if.sv */
interface gclcf_in_if import gclcf_pkg::*;;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [BYTE_W-1:0] char_in;

  modport source (output valid, func, char_in, input ready);
  modport sink   (input valid, func, char_in, output ready);
endinterface

interface gclcf_out_if import gclcf_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last_of_line;
  logic              was_overflowed;

  modport source (output valid, out_byte, last_of_line, was_overflowed, input ready);
  modport sink   (input valid, out_byte, last_of_line, was_overflowed, output ready);
endinterface

/* hdl/gcode_line_checksum_framer_core.sv */
// channel   dir  payload                                   handshake
// in_ch     in   func[1:0], char_in[7:0]                   valid/ready
// out_ch    out  out_byte[7:0], last_of_line, was_overflowed valid/ready
//
// Characters, discard and ignored events give no beat.
// Transmit skips leading spaces, then for each byte does a registered read, then the check,
// and ends with CR and LF.
// in_ch.ready is low during transmit; the next beat is taken once the LF is loaded.
// rst_n is synchronous; the line store needs no clearing pass.
// out_ch stalls hold the transmit sequence in place.
module gcode_line_checksum_framer_core import gclcf_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  gclcf_in_if.sink    in_ch,
  gclcf_out_if.source out_ch
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  state_t   state;

  gclcf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .func     (in_ch.func),
    .stat     (stat),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .state    (state)
  );

  gclcf_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .char_in   (in_ch.char_in),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_byte  (out_ch.out_byte),
    .out_last  (out_ch.last_of_line),
    .out_ovf   (out_ch.was_overflowed)
  );

  a_last_is_lf: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.last_of_line |-> out_ch.out_byte == CHAR_LF)
    else $error("last beat is not LF");

  a_lf_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load && cmd.out_sel == OSEL_LF |=> !stat.cnt_nz && state == S_WAIT)
    else $error("line not cleared after LF");

  a_no_in_during_tx: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> !in_ch.ready)
    else $error("input taken during transmit");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> stat.out_free)
    else $error("output register overwritten");

endmodule

/* hdl/gclcf_datapath.sv */
module gclcf_datapath import gclcf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [BYTE_W-1:0] char_in,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_last,
  output logic              out_ovf
);

  logic [BYTE_W-1:0] mem [LINE_DEPTH];

  logic [BYTE_W-1:0] csum_r, csum_nxt;
  logic [BYTE_W-1:0] rsum_r, rsum_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              ovf_r, ovf_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [BYTE_W-1:0] rd_data_r;
  logic              oval_r, oval_nxt;
  logic [BYTE_W-1:0] obyte_r, obyte_nxt;
  logic              olast_r, olast_nxt;
  logic              oovf_r, oovf_nxt;
  logic              has_room;
  logic              out_free;

  assign has_room = cnt_r < CNT_W'(LINE_DEPTH);
  assign out_free = !oval_r || out_ready;

  always_comb begin
    stat.is_digit  = char_in inside {[CHAR_0:CHAR_9]};
    stat.is_nl     = char_in inside {CHAR_LF, CHAR_CR};
    stat.is_n      = char_in == CHAR_N;
    stat.is_star   = char_in == CHAR_STAR;
    stat.is_quote  = char_in == CHAR_QUOTE;
    stat.sum_match = rsum_r == csum_r;
    stat.cnt_nz    = cnt_r != '0;
    stat.idx_end   = idx_r == cnt_r;
    stat.rd_space  = rd_data_r == CHAR_SPACE;
    stat.out_free  = out_free;
  end

  always_comb begin
    csum_nxt  = csum_r;
    rsum_nxt  = rsum_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    idx_nxt   = idx_r;
    oval_nxt  = oval_r && !out_ready;
    obyte_nxt = obyte_r;
    olast_nxt = olast_r;
    oovf_nxt  = oovf_r;
    if (cmd.sum_load) csum_nxt = char_in;
    if (cmd.sum_xor)  csum_nxt = csum_r ^ char_in;
    if (cmd.rsum_clr) rsum_nxt = '0;
    // 10*r + digit, wraps at 8 bits
    if (cmd.rsum_acc) rsum_nxt = (rsum_r << 3) + (rsum_r << 1) + {4'd0, char_in[3:0]};
    if (cmd.store) begin
      if (has_room) cnt_nxt = cnt_r + 1'b1;
      else          ovf_nxt = 1'b1;
    end
    if (cmd.idx_clr) idx_nxt = '0;
    if (cmd.idx_inc) idx_nxt = idx_r + 1'b1;
    if (cmd.out_load) begin
      oval_nxt = 1'b1;
      oovf_nxt = ovf_r;
      case (cmd.out_sel)
        OSEL_DATA: begin obyte_nxt = rd_data_r; olast_nxt = 1'b0; end
        OSEL_CR:   begin obyte_nxt = CHAR_CR;   olast_nxt = 1'b0; end
        OSEL_LF:   begin obyte_nxt = CHAR_LF;   olast_nxt = 1'b1; end
        default:   begin obyte_nxt = CHAR_LF;   olast_nxt = 1'b1; end
      endcase
    end
    if (cmd.clear) begin
      cnt_nxt = '0;
      ovf_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      csum_r <= '0;
      rsum_r <= '0;
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
      idx_r  <= '0;
      oval_r <= 1'b0;
    end else begin
      csum_r <= csum_nxt;
      rsum_r <= rsum_nxt;
      cnt_r  <= cnt_nxt;
      ovf_r  <= ovf_nxt;
      idx_r  <= idx_nxt;
      oval_r <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
    oovf_r  <= oovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.store && has_room) mem[cnt_r[IDX_W-1:0]] <= char_in;
    if (cmd.rd_en) rd_data_r <= mem[idx_r[IDX_W-1:0]];
  end

  assign out_valid = oval_r;
  assign out_byte  = obyte_r;
  assign out_last  = olast_r;
  assign out_ovf   = oovf_r;

endmodule

/* hdl/gclcf_ctrl.sv */
module gclcf_ctrl import gclcf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [FUNC_W-1:0] func,
  input  dp_stat_t          stat,
  output logic              in_ready,
  output dp_cmd_t           cmd,
  output state_t            state
);

  state_t state_r, state_nxt, pstate;
  logic   accept;

  assign in_ready = state_r inside {S_WAIT, S_LINENO, S_CMD, S_QUOTE, S_SUM, S_READY};
  assign accept   = in_valid && in_ready;
  assign state    = state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_WAIT;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.out_sel = OSEL_DATA;
    // a non-digit after the line number is the first command byte
    pstate = (state_r == S_LINENO) ? S_CMD : state_r;
    case (state_r)
      S_WAIT, S_LINENO, S_CMD, S_QUOTE, S_SUM, S_READY: begin
        if (accept && func == FUNC_DISCARD) begin
          cmd.clear = 1'b1;
          state_nxt = S_WAIT;
        end else if (accept && func == FUNC_TX && state_r == S_READY) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_SKIP_RD;
        end else if (accept && func == FUNC_CHAR) begin
          if (state_r == S_LINENO && stat.is_digit) begin
            cmd.sum_xor = 1'b1;
          end else begin
            case (pstate)
              S_WAIT: begin
                if (stat.is_n) begin
                  cmd.sum_load = 1'b1;
                  state_nxt    = S_LINENO;
                end
              end
              S_CMD: begin
                if (stat.is_star) begin
                  cmd.rsum_clr = 1'b1;
                  state_nxt    = S_SUM;
                end else if (stat.is_nl) begin
                  cmd.clear = 1'b1;
                  state_nxt = S_WAIT;
                end else begin
                  cmd.store   = 1'b1;
                  cmd.sum_xor = 1'b1;
                  state_nxt   = stat.is_quote ? S_QUOTE : S_CMD;
                end
              end
              S_QUOTE: begin
                if (stat.is_nl) begin
                  cmd.clear = 1'b1;
                  state_nxt = S_WAIT;
                end else begin
                  cmd.store   = 1'b1;
                  cmd.sum_xor = 1'b1;
                  state_nxt   = stat.is_quote ? S_CMD : S_QUOTE;
                end
              end
              S_SUM: begin
                if (stat.is_nl) begin
                  if (stat.sum_match && stat.cnt_nz) begin
                    state_nxt = S_READY;
                  end else begin
                    cmd.clear = 1'b1;
                    state_nxt = S_WAIT;
                  end
                end else if (stat.is_digit) begin
                  cmd.rsum_acc = 1'b1;
                end else begin
                  cmd.clear = 1'b1;
                  state_nxt = S_WAIT;
                end
              end
              default: ;
            endcase
          end
        end
      end
      S_SKIP_RD: begin
        if (stat.idx_end) begin
          state_nxt = S_CR;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_SKIP_CHK;
        end
      end
      S_SKIP_CHK: begin
        if (stat.rd_space) begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SKIP_RD;
        end else begin
          state_nxt = S_CHK;
        end
      end
      S_RD: begin
        if (stat.idx_end) begin
          state_nxt = S_CR;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_DATA;
          cmd.idx_inc  = 1'b1;
          state_nxt    = S_RD;
        end
      end
      S_CR: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_CR;
          state_nxt    = S_LF;
        end
      end
      S_LF: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_LF;
          cmd.clear    = 1'b1;
          state_nxt    = S_WAIT;
        end
      end
      default: state_nxt = S_WAIT;
    endcase
  end

endmodule
